>>> hw/rtl/mrtu_pkg.sv
`default_nettype none
package mrtu_pkg;
   localparam int RegCountDefault = 16;
   localparam int FrameMaxDefault = 64;
   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'hA001;
   localparam logic [7:0] FcRead = 8'h03;
   localparam logic [7:0] FcWrite = 8'h06;
   localparam logic [7:0] ExcIllegalFunc = 8'h01;
   localparam logic [7:0] ExcIllegalAddr = 8'h02;
   localparam logic [7:0] ExcIllegalValue = 8'h03;
   localparam logic [7:0] ExcFlag = 8'h80;
   localparam logic [15:0] ReadCountMax = 16'd125;

   typedef enum logic [1:0] {
      KIND_RX = 2'd0,
      KIND_SILENCE = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_READ = 2'd3
   } kind_type;

   typedef struct packed {
      logic start;
      logic [7:0] data;
   } crc_cmd_type;
endpackage
`default_nettype wire

>>> hw/rtl/mrtu_crc.sv
`default_nettype none
module mrtu_crc (
   input wire logic clock,
   input wire logic reset,
   input wire logic init,
   input wire mrtu_pkg::crc_cmd_type cmd,
   output logic busy,
   output logic [15:0] crc
);
   import mrtu_pkg::*;

   logic [15:0] crc_ff, crc_in;
   logic [7:0] sh_ff, sh_in;
   logic [3:0] cnt_ff, cnt_in;
   logic fb;

   always_comb begin
      crc_in = crc_ff;
      sh_in = sh_ff;
      cnt_in = cnt_ff;
      fb = crc_ff[0] ^ sh_ff[0];
      if (init) begin
         crc_in = CrcInit;
         cnt_in = '0;
      end else if (cmd.start) begin
         sh_in = cmd.data;
         cnt_in = 4'd8;
      end else if (cnt_ff != 4'd0) begin
         crc_in = {1'b0, crc_ff[15:1]} ^ (fb ? CrcPoly : 16'h0000);
         sh_in = {1'b0, sh_ff[7:1]};
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CrcInit;
         cnt_ff <= '0;
      end else begin
         crc_ff <= crc_in;
         cnt_ff <= cnt_in;
      end
      sh_ff <= sh_in;
   end

   assign busy = (cnt_ff != 4'd0);
   assign crc = crc_ff;
endmodule
`default_nettype wire

>>> hw/rtl/modbus_rtu_slave_register_server.sv
`default_nettype none
// Channel   | Direction | Ports
// request   | in        | req_valid/req_ready, req_kind, req_rx_byte, req_local_*
// response  | out       | rsp_valid/rsp_ready, rsp_out_kind, rsp_tx_byte, ...
// config    | in        | csr_write_enable, csr_write_data
// A received byte is shifted into the CRC in mrtu_crc, one bit a cycle.
// A frame end runs the check, then each message byte is loaded, shifted through
// the CRC, settled and sent, and each CRC byte is sent directly, each byte also
// waiting for rsp_ready. Local writes go straight to the store; reads via S_LOCAL.
// Reset is synchronous and clears the store, counters and CRC at once.
// A stalled response holds its byte in the output register.
module modbus_rtu_slave_register_server #(
   parameter int REG_COUNT = mrtu_pkg::RegCountDefault,
   parameter int FRAME_MAX = mrtu_pkg::FrameMaxDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [1:0] req_kind,
   input wire logic [7:0] req_rx_byte,
   input wire logic [15:0] req_local_address,
   input wire logic [15:0] req_local_value,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic rsp_out_kind,
   output logic [7:0] rsp_tx_byte,
   output logic rsp_last_of_frame,
   output logic [15:0] rsp_read_value,
   input wire logic csr_write_enable,
   input wire logic [7:0] csr_write_data
);
   import mrtu_pkg::*;

   localparam int IdxW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int LenW = $clog2(3 + 2 * REG_COUNT + 3);

   typedef enum logic [2:0] {
      S_IDLE, S_RXCRC, S_CHECK, S_BYTE, S_BCRC, S_SEND, S_LOCAL
   } state_type;

   state_type state_ff;
   logic [7:0] addr_ff;
   logic [7:0] hdr_ff [6];
   logic [6:0] count_ff;
   logic [15:0] store_ff [REG_COUNT];
   logic rvalid_ff, rkind_ff, rlast_ff;
   logic [7:0] rbyte_ff;
   logic [15:0] rval_ff;
   logic [LenW-1:0] pos_ff, len_ff;
   logic [15:0] rd_ff;
   logic [7:0] exc_fc_ff, exc_code_ff;
   logic exc_ff, wr_ff, frame_end_ff;
   logic [15:0] rstart_ff, rn_ff;

   logic crc_init;
   crc_cmd_type crc_cmd;
   logic crc_busy;
   logic [15:0] crc_val;

   mrtu_crc u_crc (
      .clock(clock), .reset(reset), .init(crc_init), .cmd(crc_cmd),
      .busy(crc_busy), .crc(crc_val)
   );

   logic [15:0] h23, h45;
   logic [7:0] msg_byte;
   logic [LenW-1:0] rel;
   logic [15:0] ridx;
   assign h23 = {hdr_ff[2], hdr_ff[3]};
   assign h45 = {hdr_ff[4], hdr_ff[5]};
   assign rel = pos_ff - LenW'(3);
   assign ridx = rstart_ff + 16'(rel[LenW-1:1]);

   always_comb begin
      msg_byte = 8'h00;
      if (exc_ff) begin
         unique case (pos_ff)
            LenW'(0): msg_byte = addr_ff;
            LenW'(1): msg_byte = exc_fc_ff | ExcFlag;
            default: msg_byte = exc_code_ff;
         endcase
      end else if (wr_ff) begin
         msg_byte = hdr_ff[pos_ff[2:0]];
      end else begin
         priority if (pos_ff == LenW'(0)) msg_byte = addr_ff;
         else if (pos_ff == LenW'(1)) msg_byte = FcRead;
         else if (pos_ff == LenW'(2)) msg_byte = {rn_ff[6:0], 1'b0};
         else if (rel[0]) msg_byte = store_ff[ridx[IdxW-1:0]][7:0];
         else msg_byte = store_ff[ridx[IdxW-1:0]][15:8];
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !rvalid_ff;
   logic acc;
   assign acc = req_valid && req_ready;

   always_comb begin
      crc_init = 1'b0;
      crc_cmd = '0;
      if (acc && req_kind == KIND_RX) begin
         crc_cmd.start = 1'b1;
         crc_cmd.data = req_rx_byte;
      end else if (state_ff == S_CHECK) begin
         crc_init = 1'b1;
      end else if (state_ff == S_BYTE) begin
         crc_cmd.start = 1'b1;
         crc_cmd.data = msg_byte;
      end else if (state_ff == S_SEND && !rvalid_ff && pos_ff == len_ff + LenW'(1)) begin
         crc_init = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         addr_ff <= 8'd1;
         count_ff <= '0;
         rvalid_ff <= 1'b0;
         for (int i = 0; i < REG_COUNT; i++) store_ff[i] <= '0;
      end else begin
         if (csr_write_enable) addr_ff <= csr_write_data;
         if (rvalid_ff && rsp_ready) rvalid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (acc) begin
                  unique case (kind_type'(req_kind))
                     KIND_RX: begin
                        if (count_ff < 7'd6) hdr_ff[count_ff[2:0]] <= req_rx_byte;
                        count_ff <= count_ff + 7'd1;
                        frame_end_ff <= (count_ff + 7'd1 >= 7'(FRAME_MAX));
                        state_ff <= S_RXCRC;
                     end
                     KIND_SILENCE: begin
                        if (count_ff != 7'd0) state_ff <= S_CHECK;
                     end
                     KIND_WRITE: begin
                        if (req_local_address < 16'(REG_COUNT))
                           store_ff[req_local_address[IdxW-1:0]] <= req_local_value;
                     end
                     KIND_READ: begin
                        rd_ff <= (req_local_address < 16'(REG_COUNT)) ?
                           store_ff[req_local_address[IdxW-1:0]] : 16'h0000;
                        state_ff <= S_LOCAL;
                     end
                     default: ;
                  endcase
               end
            end
            S_LOCAL: begin
               rvalid_ff <= 1'b1;
               rkind_ff <= 1'b1;
               rbyte_ff <= 8'h00;
               rlast_ff <= 1'b0;
               rval_ff <= rd_ff;
               state_ff <= S_IDLE;
            end
            S_RXCRC: begin
               if (!crc_busy && !crc_cmd.start)
                  state_ff <= frame_end_ff ? S_CHECK : S_IDLE;
            end
            S_CHECK: begin
               count_ff <= '0;
               pos_ff <= '0;
               rstart_ff <= h23;
               rn_ff <= h45;
               exc_ff <= 1'b1;
               wr_ff <= 1'b0;
               exc_fc_ff <= hdr_ff[1];
               len_ff <= LenW'(3);
               state_ff <= S_BYTE;
               if (count_ff < 7'd4 || (hdr_ff[0] != addr_ff && hdr_ff[0] != 8'h00)
                   || crc_val != 16'h0000) begin
                  state_ff <= S_IDLE;
               end else if (hdr_ff[1] == FcRead) begin
                  if (count_ff != 7'd8 || h45 == 16'd0 || h45 > ReadCountMax)
                     exc_code_ff <= ExcIllegalValue;
                  else if (17'(h23) + 17'(h45) > 17'(REG_COUNT))
                     exc_code_ff <= ExcIllegalAddr;
                  else begin
                     exc_ff <= 1'b0;
                     len_ff <= LenW'(3) + LenW'({h45[5:0], 1'b0});
                  end
               end else if (hdr_ff[1] == FcWrite) begin
                  if (count_ff != 7'd8) exc_code_ff <= ExcIllegalValue;
                  else if (h23 >= 16'(REG_COUNT)) exc_code_ff <= ExcIllegalAddr;
                  else begin
                     exc_ff <= 1'b0;
                     wr_ff <= 1'b1;
                     len_ff <= LenW'(6);
                     store_ff[h23[IdxW-1:0]] <= h45;
                  end
               end else begin
                  exc_code_ff <= ExcIllegalFunc;
               end
            end
            S_BYTE: state_ff <= S_BCRC;
            S_BCRC: if (!crc_busy) state_ff <= S_SEND;
            S_SEND: begin
               if (!rvalid_ff) begin
                  rvalid_ff <= 1'b1;
                  rkind_ff <= 1'b0;
                  rval_ff <= '0;
                  pos_ff <= pos_ff + LenW'(1);
                  if (pos_ff == len_ff) begin
                     rbyte_ff <= crc_val[7:0];
                     rlast_ff <= 1'b0;
                  end else if (pos_ff == len_ff + LenW'(1)) begin
                     rbyte_ff <= crc_val[15:8];
                     rlast_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     rbyte_ff <= msg_byte;
                     rlast_ff <= 1'b0;
                     if (pos_ff + LenW'(1) != len_ff) state_ff <= S_BYTE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rvalid_ff;
   assign rsp_out_kind = rkind_ff;
   assign rsp_tx_byte = rbyte_ff;
   assign rsp_last_of_frame = rlast_ff;
   assign rsp_read_value = rval_ff;
endmodule
`default_nettype wire

>>> hw/rtl/mrtu_checker.sv
`default_nettype none
module mrtu_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_out_kind,
   input wire logic [7:0] rsp_tx_byte,
   input wire logic rsp_last_of_frame,
   input wire logic [15:0] rsp_read_value
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte))
      else $error("response dropped while stalled");
   a_local_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind |-> !rsp_last_of_frame && rsp_tx_byte == 8'h00)
      else $error("local read carries frame data");
   a_tx_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_kind |-> rsp_read_value == 16'h0000)
      else $error("transmit byte carries read data");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken with result pending");
endmodule

bind modbus_rtu_slave_register_server mrtu_checker u_chk (.*);
`default_nettype wire
